FILE: rtl/bzs_pkg.sv
// Shared types and arithmetic for the cubic Bezier subdivision pipeline.
package bzs_pkg;

    localparam int unsigned CoordW = 32;
    localparam int unsigned ParamW = 17;
    localparam int unsigned FracW  = 16;
    localparam logic [ParamW-1:0] OneQ16 = 17'h10000;
    localparam int unsigned NumSlots = 7;

    // Command codes
    localparam logic CmdSplit   = 1'b0;
    localparam logic CmdSubpath = 1'b1;

    // Ratio source for the subpath cut
    typedef enum logic [1:0] {
        RATIO_DIV  = 2'd0,
        RATIO_ZERO = 2'd1,
        RATIO_ONE  = 2'd2
    } t_ratio_sel;

    // Seven working coordinates of one axis
    typedef logic [NumSlots-1:0][CoordW-1:0] t_slots;

    // Floor lerp: a + floor(t * (b - a) / 2^16), always within [a, b]
    function automatic logic [CoordW-1:0] lerp(input logic [CoordW-1:0] a,
                                               input logic [CoordW-1:0] b,
                                               input logic [ParamW-1:0] t);
        logic signed [CoordW:0]   diff;
        logic signed [CoordW+ParamW+1:0] prod;
        diff = $signed({b[CoordW-1], b}) - $signed({a[CoordW-1], a});
        prod = diff * $signed({1'b0, t});
        return a + prod[CoordW+FracW-1:FracW];
    endfunction

endpackage

FILE: rtl/cubic_bezier_subdivide_top.sv
// Top level: eight-stage de Casteljau pipeline with ratio divider and output serializer.
// An input passes stages 1 to 8 and the serializer before its first point goes out.
// Throughput: one point per cycle while i_m_tready is high; split items send 8 points,
//   subpath items 4, over the single-point output channel.
// The ratio divider retires 4 quotient bits per stage over stages 1 to 4.
// Reset (synchronous, active low) clears all valid bits and the serializer.
module cubic_bezier_subdivide_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [295:0] i_s_tdata,  // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x,
                                     // ctrl2_y, end_x, end_y, split_t, sub_start_t, pad
    input  logic         i_s_tuser,  // command
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [63:0]  o_m_tdata,  // point_x, point_y
    output logic [2:0]   o_m_tuser,  // half, point_index[1:0]
    output logic         o_m_tlast
);
    import bzs_pkg::*;

    logic              r_v     [1:8];
    logic              r_cmd   [1:8];
    t_slots            r_px    [1:8];
    t_slots            r_py    [1:8];
    logic [ParamW-1:0] r_t     [1:4];
    logic [ParamW-1:0] r_rem   [1:4];
    logic [FracW-1:0]  r_q     [1:4];
    t_ratio_sel        r_sel   [1:4];
    logic [ParamW-1:0] r_ratio [5:7];

    t_slots            n_px    [2:8];
    t_slots            n_py    [2:8];
    logic [ParamW-1:0] n_rem   [2:5];
    logic [FracW-1:0]  n_q     [2:5];
    logic [ParamW-1:0] n_ratio;

    logic              en;
    logic              take;
    logic [ParamW-1:0] in_t2;
    logic [ParamW-1:0] in_t1;
    logic [ParamW-1:0] raw_t2;
    logic [ParamW-1:0] raw_t1;
    t_ratio_sel        in_sel;
    t_slots            in_px;
    t_slots            in_py;

    // Whole pipeline moves when its last stage is empty or handed over
    assign en         = !r_v[8] || take;
    assign o_s_tready = en;

    // Input unpack and parameter clamp
    always_comb begin
        raw_t2 = i_s_tdata[272:256];
        raw_t1 = i_s_tdata[289:273];
        in_t2  = (raw_t2[16] && (|raw_t2[15:0])) ? OneQ16 : raw_t2;
        in_t1  = (raw_t1[16] && (|raw_t1[15:0])) ? OneQ16 : raw_t1;
        if (in_t2 == '0) begin
            in_sel = RATIO_ZERO;
        end else if (in_t1 >= in_t2) begin
            in_sel = RATIO_ONE;
        end else begin
            in_sel = RATIO_DIV;
        end
        in_px = '0;
        in_py = '0;
        for (int k = 0; k < 4; k++) begin
            in_px[k] = i_s_tdata[64*k +: 32];
            in_py[k] = i_s_tdata[64*k+32 +: 32];
        end
    end

    // Restoring divider, four quotient bits per stage
    always_comb begin
        logic [ParamW:0]   rem_sh;
        logic [ParamW-1:0] rem;
        logic [FracW-1:0]  q;
        for (int s = 1; s < 5; s++) begin
            rem = r_rem[s];
            q   = r_q[s];
            for (int b = 0; b < 4; b++) begin
                rem_sh = {rem, 1'b0};
                if (rem_sh >= {1'b0, r_t[s]}) begin
                    rem_sh = rem_sh - {1'b0, r_t[s]};
                    q      = {q[FracW-2:0], 1'b1};
                end else begin
                    q      = {q[FracW-2:0], 1'b0};
                end
                rem = rem_sh[ParamW-1:0];
            end
            n_rem[s+1] = rem;
            n_q[s+1]   = q;
        end
        unique case (r_sel[4])
            RATIO_ZERO: n_ratio = '0;
            RATIO_ONE:  n_ratio = OneQ16;
            default:    n_ratio = {1'b0, n_q[5]};
        endcase
    end

    // Interpolation levels, x and y in parallel
    always_comb begin
        // first split at t2
        n_px[2]    = r_px[1];
        n_px[2][1] = lerp(r_px[1][0], r_px[1][1], r_t[1]);
        n_px[2][2] = lerp(r_px[1][1], r_px[1][2], r_t[1]);
        n_px[2][3] = lerp(r_px[1][2], r_px[1][3], r_t[1]);
        n_px[2][4] = r_px[1][3];
        n_py[2]    = r_py[1];
        n_py[2][1] = lerp(r_py[1][0], r_py[1][1], r_t[1]);
        n_py[2][2] = lerp(r_py[1][1], r_py[1][2], r_t[1]);
        n_py[2][3] = lerp(r_py[1][2], r_py[1][3], r_t[1]);
        n_py[2][4] = r_py[1][3];

        n_px[3]    = r_px[2];
        n_px[3][2] = lerp(r_px[2][1], r_px[2][2], r_t[2]);
        n_px[3][3] = lerp(r_px[2][2], r_px[2][3], r_t[2]);
        n_px[3][4] = r_px[2][3];
        n_px[3][5] = r_px[2][4];
        n_py[3]    = r_py[2];
        n_py[3][2] = lerp(r_py[2][1], r_py[2][2], r_t[2]);
        n_py[3][3] = lerp(r_py[2][2], r_py[2][3], r_t[2]);
        n_py[3][4] = r_py[2][3];
        n_py[3][5] = r_py[2][4];

        n_px[4]    = r_px[3];
        n_px[4][3] = lerp(r_px[3][2], r_px[3][3], r_t[3]);
        n_px[4][4] = r_px[3][3];
        n_px[4][5] = r_px[3][4];
        n_px[4][6] = r_px[3][5];
        n_py[4]    = r_py[3];
        n_py[4][3] = lerp(r_py[3][2], r_py[3][3], r_t[3]);
        n_py[4][4] = r_py[3][3];
        n_py[4][5] = r_py[3][4];
        n_py[4][6] = r_py[3][5];

        n_px[5] = r_px[4];
        n_py[5] = r_py[4];

        // second split of the first half at the ratio, subpath only
        n_px[6] = r_px[5];
        n_py[6] = r_py[5];
        if (r_cmd[5] == CmdSubpath) begin
            n_px[6][0] = lerp(r_px[5][0], r_px[5][1], r_ratio[5]);
            n_px[6][1] = lerp(r_px[5][1], r_px[5][2], r_ratio[5]);
            n_px[6][2] = lerp(r_px[5][2], r_px[5][3], r_ratio[5]);
            n_py[6][0] = lerp(r_py[5][0], r_py[5][1], r_ratio[5]);
            n_py[6][1] = lerp(r_py[5][1], r_py[5][2], r_ratio[5]);
            n_py[6][2] = lerp(r_py[5][2], r_py[5][3], r_ratio[5]);
        end

        n_px[7] = r_px[6];
        n_py[7] = r_py[6];
        if (r_cmd[6] == CmdSubpath) begin
            n_px[7][0] = lerp(r_px[6][0], r_px[6][1], r_ratio[6]);
            n_px[7][1] = lerp(r_px[6][1], r_px[6][2], r_ratio[6]);
            n_py[7][0] = lerp(r_py[6][0], r_py[6][1], r_ratio[6]);
            n_py[7][1] = lerp(r_py[6][1], r_py[6][2], r_ratio[6]);
        end

        n_px[8] = r_px[7];
        n_py[8] = r_py[7];
        if (r_cmd[7] == CmdSubpath) begin
            n_px[8][0] = lerp(r_px[7][0], r_px[7][1], r_ratio[7]);
            n_py[8][0] = lerp(r_py[7][0], r_py[7][1], r_ratio[7]);
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s < 9; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (en) begin
            r_v[1] <= i_s_tvalid;
            for (int s = 2; s < 9; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd[1] <= i_s_tuser;
            r_px[1]  <= in_px;
            r_py[1]  <= in_py;
            r_t[1]   <= in_t2;
            r_rem[1] <= in_t1;
            r_q[1]   <= '0;
            r_sel[1] <= in_sel;
            for (int s = 2; s < 9; s++) begin
                r_cmd[s] <= r_cmd[s-1];
                r_px[s]  <= n_px[s];
                r_py[s]  <= n_py[s];
            end
            for (int s = 2; s < 5; s++) begin
                r_t[s]   <= r_t[s-1];
                r_rem[s] <= n_rem[s];
                r_q[s]   <= n_q[s];
                r_sel[s] <= r_sel[s-1];
            end
            r_ratio[5] <= n_ratio;
            r_ratio[6] <= r_ratio[5];
            r_ratio[7] <= r_ratio[6];
        end
    end

    bzs_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v[8]),
        .i_cmd      (r_cmd[8]),
        .i_px       (r_px[8]),
        .i_py       (r_py[8]),
        .o_take     (take),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

FILE: rtl/bzs_out.sv
// Output serializer: holds one finished curve set and sends one point per transfer.
module bzs_out (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_cmd,
    input  bzs_pkg::t_slots      i_px,
    input  bzs_pkg::t_slots      i_py,
    output logic                 o_take,
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [63:0]          o_m_tdata,   // point_x, point_y
    output logic [2:0]           o_m_tuser,   // half, point_index[1:0]
    output logic                 o_m_tlast
);
    import bzs_pkg::*;

    logic [CoordW-1:0] r_bx [0:7];
    logic [CoordW-1:0] r_by [0:7];
    logic              r_busy;
    logic              r_cmd;
    logic [2:0]        r_cnt;
    logic              is_last;
    logic              xfer;

    assign xfer    = r_busy && i_m_tready;
    assign is_last = (r_cmd == CmdSubpath) ? (r_cnt == 3'd3) : (r_cnt == 3'd7);
    assign o_take  = i_valid && (!r_busy || (xfer && is_last));

    // Control: busy flag and point counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
        end else if (o_take) begin
            r_busy <= 1'b1;
            r_cnt  <= 3'd0;
        end else if (xfer) begin
            r_busy <= !is_last;
            r_cnt  <= r_cnt + 3'd1;
        end
    end

    // Payload: split maps slots {0,1,2,3,3,4,5,6}; subpath uses slots 0..3
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cmd <= i_cmd;
            for (int k = 0; k < 4; k++) begin
                r_bx[k] <= i_px[k];
                r_by[k] <= i_py[k];
            end
            r_bx[4] <= i_px[3];
            r_by[4] <= i_py[3];
            for (int k = 5; k < 8; k++) begin
                r_bx[k] <= i_px[k-1];
                r_by[k] <= i_py[k-1];
            end
        end
    end

    assign o_m_tvalid = r_busy;
    assign o_m_tdata  = {r_by[r_cnt], r_bx[r_cnt]};
    assign o_m_tuser  = {r_cnt[1:0], r_cnt[2]};
    assign o_m_tlast  = is_last;

endmodule

FILE: bench/tb_top.sv
// Testbench for the cubic Bezier subdivision block: directed and random curves.
`timescale 1ns / 100ps

module tb_top;
    import bzs_pkg::*;

    // One expected output point
    typedef struct packed {
        logic [31:0] px;
        logic [31:0] py;
        logic        half;
        logic [1:0]  idx;
        logic        last;
    } t_point;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [295:0] i_s_tdata;  // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x,
                              // ctrl2_y, end_x, end_y, split_t, sub_start_t, pad
    logic         i_s_tuser;  // command
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [63:0]  o_m_tdata;  // point_x, point_y
    logic [2:0]   o_m_tuser;  // half, point_index[1:0]
    logic         o_m_tlast;

    t_point       pending_points[$];
    int           n_errors;
    int unsigned  cycle_count;
    bit           rx_stall_on;
    int unsigned  rx_count = 0;
    int unsigned  rx_seen;
    int unsigned  rx_wait;

    cubic_bezier_subdivide_top dut (.*);

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Floor interpolation on offset-binary values
    function automatic logic [31:0] interp(logic [31:0] a, logic [31:0] b, logic [16:0] t);
        logic [63:0] ua, ub, s;
        ua = {32'd0, a ^ 32'h8000_0000};
        ub = {32'd0, b ^ 32'h8000_0000};
        s = ((64'd65536 - t) * ua + t * ub) >> 16;
        return s[31:0] ^ 32'h8000_0000;
    endfunction

    // de Casteljau cut of one axis: lo[0..3], hi[0..3]
    task automatic cut_axis(input logic [31:0] p[4], input logic [16:0] t,
                            output logic [31:0] lo[4], output logic [31:0] hi[4]);
        logic [31:0] a, b, d, ab, bd, m;
        a = interp(p[0], p[1], t);
        b = interp(p[1], p[2], t);
        d = interp(p[2], p[3], t);
        ab = interp(a, b, t);
        bd = interp(b, d, t);
        m = interp(ab, bd, t);
        lo = '{p[0], a, ab, m};
        hi = '{m, bd, d, p[3]};
    endtask

    // Expected points for one curve transfer
    task automatic predict_points(input logic cmd, input logic [31:0] cx[4],
                                  input logic [31:0] cy[4], input logic [16:0] ts,
                                  input logic [16:0] ss);
        logic [31:0] lx[4], ly[4], hx[4], hy[4], l2x[4], l2y[4], h2x[4], h2y[4];
        logic [16:0] t2, t1, ratio;
        logic [63:0] r;
        t2 = (ts > OneQ16) ? OneQ16 : ts;
        t1 = (ss > OneQ16) ? OneQ16 : ss;
        cut_axis(cx, t2, lx, hx);
        cut_axis(cy, t2, ly, hy);
        if (cmd == CmdSplit) begin
            for (int i = 0; i < 4; i++)
                pending_points.push_back('{lx[i], ly[i], 1'b0, i[1:0], 1'b0});
            for (int i = 0; i < 4; i++)
                pending_points.push_back('{hx[i], hy[i], 1'b1, i[1:0], i == 3});
        end else begin
            ratio = '0;
            if (t2 != 0) begin
                r = ({47'd0, t1} << 16) / t2;
                ratio = (r > 65536) ? OneQ16 : r[16:0];
            end
            cut_axis(lx, ratio, l2x, h2x);
            cut_axis(ly, ratio, l2y, h2y);
            for (int i = 0; i < 4; i++)
                pending_points.push_back('{h2x[i], h2y[i], 1'b0, i[1:0], i == 3});
        end
    endtask

    // Send one curve and queue its expected points; returns at a falling edge
    task automatic send_curve(input logic cmd, input logic [31:0] cx[4],
                              input logic [31:0] cy[4], input logic [16:0] ts,
                              input logic [16:0] ss);
        int unsigned idle_cycles;
        idle_cycles = $urandom_range(0, 4);
        if (idle_cycles != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (idle_cycles) @(negedge i_clk);
        end
        i_s_tdata <= {6'd0, ss, ts, cy[3], cx[3], cy[2], cx[2], cy[1], cx[1], cy[0], cx[0]};
        i_s_tuser <= cmd;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        predict_points(cmd, cx, cy, ts, ss);
        @(negedge i_clk);
    endtask

    // Random coordinate, often from an extreme
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom_range(0, 65535) - 32768;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [16:0] rand_param();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return OneQ16;
            2: return 17'h1FFFF - 17'($urandom_range(0, 65534));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // Input goes idle, then wait for every expected point
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (pending_points.size() != 0) @(posedge i_clk);
    endtask

    // Extreme coordinates and parameters in both modes
    task automatic test_extremes();
        logic [31:0] cx[4], cy[4];
        cx = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF};
        cy = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
        send_curve(CmdSplit, cx, cy, 17'd0, 17'd0);
        send_curve(CmdSplit, cx, cy, OneQ16, 17'h1FFFF);
        send_curve(CmdSplit, cx, cy, 17'h8000, 17'd0);
        send_curve(CmdSplit, cx, cy, 17'h1FFFF, 17'd5);
        send_curve(CmdSubpath, cx, cy, 17'h1FFFF, 17'h4000);
        send_curve(CmdSubpath, cy, cx, 17'h0FFFF, 17'h0FFFF);
        send_curve(CmdSplit, cy, cx, 17'd1, 17'h1FFFF);
    endtask

    // Subpath corners: end zero, start beyond end, parameters above one
    task automatic test_subpath_cases();
        logic [31:0] cx[4], cy[4];
        for (int i = 0; i < 4; i++) begin
            cx[i] = rand_coord();
            cy[i] = rand_coord();
        end
        send_curve(CmdSubpath, cx, cy, 17'd0, 17'h8000);
        send_curve(CmdSubpath, cx, cy, 17'd0, 17'd0);
        send_curve(CmdSubpath, cx, cy, 17'h4000, 17'hC000);
        send_curve(CmdSubpath, cx, cy, 17'h1FFFF, 17'h1FFFF);
        send_curve(CmdSubpath, cx, cy, OneQ16, 17'd0);
        send_curve(CmdSubpath, cx, cy, 17'h3, 17'h1);
        send_curve(CmdSubpath, cx, cy, 17'h6000, 17'h2000);
        send_curve(CmdSubpath, cx, cy, 17'h10001, 17'h1234);
        // sender holds off until every point is back
        wait_drained();
    endtask

    // Random curves, with one burst where the receiver never stalls
    task automatic test_random(input int count);
        logic [31:0] cx[4], cy[4];
        for (int n = 0; n < count; n++) begin
            rx_stall_on = !(n >= 200 && n < 260);
            for (int i = 0; i < 4; i++) begin
                cx[i] = rand_coord();
                cy[i] = rand_coord();
            end
            send_curve(1'($urandom_range(0, 1)), cx, cy, rand_param(), rand_param());
        end
        rx_stall_on = 1'b1;
    endtask

    // Receiver backpressure: after each point, hold ready low while a random countdown runs
    always @(negedge i_clk) begin
        if (!i_rst_n || !rx_stall_on) begin
            rx_seen = rx_count;
            rx_wait = 0;
            i_m_tready <= 1'b1;
        end else begin
            if (rx_count != rx_seen) begin
                rx_seen = rx_count;
                rx_wait = $urandom_range(0, 4);
            end
            if (rx_wait > 0) begin
                rx_wait = rx_wait - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Point checker
    always @(posedge i_clk) begin
        t_point got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            rx_count++;
            got = '{o_m_tdata[31:0], o_m_tdata[63:32], o_m_tuser[0], o_m_tuser[2:1],
                    o_m_tlast};
            if (pending_points.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected point %p", got);
            end else begin
                want = pending_points.pop_front();
                if (got !== want) begin
                    n_errors++;
                    if (n_errors <= 10) $display("mismatch: expected %p got %p", want, got);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b1;
        n_errors = 0;
        cycle_count = 0;
        rx_stall_on = 1'b1;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_extremes();
        test_subpath_cases();
        test_random(490);
        wait_drained();
        repeat (30) @(posedge i_clk);
        if (n_errors == 0 && pending_points.size() == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
